[src/overlap_location_classify_extend_assert.svh]
`ifndef OVERLAP_LOCATION_CLASSIFY_EXTEND_ASSERT_SVH
`define OVERLAP_LOCATION_CLASSIFY_EXTEND_ASSERT_SVH

// same-cycle check, quiet while reset is high
`define OLCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, quiet while reset is high
`define OLCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/olce_pkg.sv]
`default_nettype none

package olce_pkg;

  localparam int OLCE_COORD_BITS = 24;
  localparam int TOL_W = 16;
  localparam int OUT_W = 26;
  localparam int LOC_W = 3;
  localparam int OUT_FIELDS_W = LOC_W + 1 + 4 * OUT_W;
  localparam int OUT_TDATA_W = 8 * ((OUT_FIELDS_W + 7) / 8);

  typedef enum logic [LOC_W-1:0] {
    LOC_LEFT       = 3'd0,
    LOC_RIGHT      = 3'd1,
    LOC_EQUAL      = 3'd2,
    LOC_CONTAINING = 3'd3,
    LOC_CONTAINED  = 3'd4,
    LOC_ABNORMAL   = 3'd5
  } loc_t;

  // restate a label as seen from read b
  function automatic loc_t flip_view(input loc_t loc, input logic same);
    loc_t r;
    case (loc)
      LOC_LEFT:       r = same ? LOC_RIGHT : LOC_LEFT;
      LOC_RIGHT:      r = same ? LOC_LEFT : LOC_RIGHT;
      LOC_CONTAINING: r = LOC_CONTAINED;
      LOC_CONTAINED:  r = LOC_CONTAINING;
      default:        r = loc;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/overlap_location_classify_extend.sv]
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the result is taken, else held off by m_tready
// a waiting result stops the next item from entering the input register only while that register is full
// reset: rst, synchronous active high, clears both valid flags; data registers keep values
`default_nettype none

`include "overlap_location_classify_extend_assert.svh"

module overlap_location_classify_extend
  import olce_pkg::*;
#(
  parameter int COORD_BITS = OLCE_COORD_BITS,
  localparam int IN_FIELDS_W = 6 * COORD_BITS + 2 + TOL_W,
  localparam int IN_TDATA_W = 8 * ((IN_FIELDS_W + 7) / 8)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // a_start, a_end, a_len, b_start, b_end, b_len, same_strand, tolerance,
  // view_from_b, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // mode
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // location, extend_ok, new_a_start, new_a_end, new_b_start, new_b_end,
  // zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  // internal coordinate width covers sums of two lengths and differences
  localparam int W = COORD_BITS + 3;
  localparam int CW = (W > OUT_W) ? W : OUT_W;
  localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [CW-1:0] SAT_LO = CW'(-(64'sd1 <<< (OUT_W - 1)));

  // field offsets inside the input word
  localparam int OFF_AS   = 0;
  localparam int OFF_AE   = COORD_BITS;
  localparam int OFF_AL   = 2 * COORD_BITS;
  localparam int OFF_BS   = 3 * COORD_BITS;
  localparam int OFF_BE   = 4 * COORD_BITS;
  localparam int OFF_BL   = 5 * COORD_BITS;
  localparam int OFF_SAME = 6 * COORD_BITS;
  localparam int OFF_TOL  = 6 * COORD_BITS + 1;
  localparam int OFF_VIEW = 6 * COORD_BITS + 1 + TOL_W;

  // clamp a coordinate into the 26-bit signed result range
  function automatic logic signed [OUT_W-1:0] sat(input logic signed [W-1:0] v);
    logic signed [CW-1:0] x;
    x = CW'(v);
    if (x > SAT_HI) x = SAT_HI;
    if (x < SAT_LO) x = SAT_LO;
    return x[OUT_W-1:0];
  endfunction

  // pipeline control
  logic adv_in, adv_out;
  logic in_valid, out_valid;

  // input register
  logic [IN_FIELDS_W-1:0] in_word;
  logic                   in_mode;

  // result register
  loc_t                    location;
  logic                    extend_ok;
  logic signed [OUT_W-1:0] new_a_start, new_a_end, new_b_start, new_b_end;

  // decoded fields of the registered item
  logic signed [W-1:0] as_w, ae_w, al_w, bs_w, be_w, bl_w;
  logic                same;
  logic                view_b;
  logic [TOL_W-1:0]    tol;

  // stretched coordinates
  logic signed [W-1:0] st_as, st_ae, st_bs, st_be;

  loc_t loc_zero, loc_tol, loc_st;
  logic do_stretch;

  loc_t                    location_next;
  logic                    extend_ok_next;
  logic signed [W-1:0]     sel_as, sel_ae, sel_bs, sel_be;

  // result stage moves when empty or taken; input stage moves when it can pass on
  assign adv_out  = !out_valid || m_tready;
  assign adv_in   = !in_valid || adv_out;
  assign s_tready = adv_in;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid <= s_tvalid;
      end
      if (adv_out) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && s_tvalid) begin
      in_word <= s_tdata[IN_FIELDS_W-1:0];
      in_mode <= s_tuser;
    end
  end

  // coordinates enter in their low COORD_BITS bits, zero extended
  assign as_w   = W'(in_word[OFF_AS +: COORD_BITS]);
  assign ae_w   = W'(in_word[OFF_AE +: COORD_BITS]);
  assign al_w   = W'(in_word[OFF_AL +: COORD_BITS]);
  assign bs_w   = W'(in_word[OFF_BS +: COORD_BITS]);
  assign be_w   = W'(in_word[OFF_BE +: COORD_BITS]);
  assign bl_w   = W'(in_word[OFF_BL +: COORD_BITS]);
  assign same   = in_word[OFF_SAME];
  assign tol    = in_word[OFF_TOL +: TOL_W];
  assign view_b = in_word[OFF_VIEW];

  // class at zero slack, on the item as given
  olce_classify #(.W(W)) u_class_zero (
    .same    (same),
    .slack   ('0),
    .a_start (as_w),
    .a_end   (ae_w),
    .a_len   (al_w),
    .b_start (bs_w),
    .b_end   (be_w),
    .b_len   (bl_w),
    .loc     (loc_zero)
  );

  // class at the given slack
  olce_classify #(.W(W)) u_class_tol (
    .same    (same),
    .slack   (tol),
    .a_start (as_w),
    .a_end   (ae_w),
    .a_len   (al_w),
    .b_start (bs_w),
    .b_end   (be_w),
    .b_len   (bl_w),
    .loc     (loc_tol)
  );

  olce_stretch #(.W(W)) u_stretch (
    .same        (same),
    .margin      (tol),
    .a_start     (as_w),
    .a_end       (ae_w),
    .a_len       (al_w),
    .b_start     (bs_w),
    .b_end       (be_w),
    .b_len       (bl_w),
    .new_a_start (st_as),
    .new_a_end   (st_ae),
    .new_b_start (st_bs),
    .new_b_end   (st_be)
  );

  // zero-slack class of the stretched overlap
  olce_classify #(.W(W)) u_class_st (
    .same    (same),
    .slack   ('0),
    .a_start (st_as),
    .a_end   (st_ae),
    .a_len   (al_w),
    .b_start (st_bs),
    .b_end   (st_be),
    .b_len   (bl_w),
    .loc     (loc_st)
  );

  // stretch only what is abnormal now but proper within the tolerance
  assign do_stretch = in_mode && (loc_zero == LOC_ABNORMAL) && (loc_tol != LOC_ABNORMAL);

  always_comb begin
    loc_t base;
    if (!in_mode) begin
      base           = loc_tol;
      extend_ok_next = 1'b0;
    end else if (loc_zero != LOC_ABNORMAL) begin
      base           = loc_zero;
      extend_ok_next = 1'b1;
    end else if (do_stretch) begin
      base           = loc_st;
      extend_ok_next = 1'b1;
    end else begin
      base           = LOC_ABNORMAL;
      extend_ok_next = 1'b0;
    end
    location_next = view_b ? flip_view(base, same) : base;
  end

  assign sel_as = do_stretch ? st_as : as_w;
  assign sel_ae = do_stretch ? st_ae : ae_w;
  assign sel_bs = do_stretch ? st_bs : bs_w;
  assign sel_be = do_stretch ? st_be : be_w;

  always_ff @(posedge clk) begin
    if (adv_out && in_valid) begin
      location    <= location_next;
      extend_ok   <= extend_ok_next;
      new_a_start <= sat(sel_as);
      new_a_end   <= sat(sel_ae);
      new_b_start <= sat(sel_bs);
      new_b_end   <= sat(sel_be);
    end
  end

  assign m_tdata = OUT_TDATA_W'({new_b_end, new_b_start, new_a_end, new_a_start,
                                 extend_ok, location});

  // a full pipe with a stalled result must hold off the input
  `OLCE_ASSERT_NOW(a_full_stall, clk, rst, in_valid && out_valid && !m_tready, !s_tready,
    "input accepted while both stages are full and stalled")

  // an accepted item lands in the input register
  `OLCE_ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, in_valid,
    "accepted item did not reach the input register")

  // classify mode never reports an extension
  `OLCE_ASSERT_NEXT(a_classify_no_ok, clk, rst, in_valid && adv_out && !in_mode,
    out_valid && !extend_ok, "classify item reported extend_ok")

  // a failed extension always reads abnormal
  `OLCE_ASSERT_NEXT(a_fail_abnormal, clk, rst,
    in_valid && adv_out && in_mode && !extend_ok_next,
    out_valid && (location == LOC_ABNORMAL), "failed extension not abnormal")

endmodule

`default_nettype wire

[src/olce_classify.sv]
`default_nettype none

module olce_classify
  import olce_pkg::*;
#(
  parameter int W = OLCE_COORD_BITS + 3
) (
  input  logic                same,
  input  logic [TOL_W-1:0]    slack,
  input  logic signed [W-1:0] a_start,
  input  logic signed [W-1:0] a_end,
  input  logic signed [W-1:0] a_len,
  input  logic signed [W-1:0] b_start,
  input  logic signed [W-1:0] b_end,
  input  logic signed [W-1:0] b_len,
  output loc_t                loc
);

  logic signed [W-1:0] sl;
  logic sa_lo, sa_hi, ea_lo, ea_hi, sb_lo, sb_hi, eb_lo, eb_hi;
  logic sa_z, ea_z, sb_z, eb_z;

  assign sl = W'(slack);

  // starts against zero, ends against the read length
  assign sa_lo = a_start < -sl;
  assign sa_hi = a_start > sl;
  assign ea_lo = a_end < (a_len - sl);
  assign ea_hi = a_end > (a_len + sl);
  assign sb_lo = b_start < -sl;
  assign sb_hi = b_start > sl;
  assign eb_lo = b_end < (b_len - sl);
  assign eb_hi = b_end > (b_len + sl);

  assign sa_z = !sa_lo && !sa_hi;
  assign ea_z = !ea_lo && !ea_hi;
  assign sb_z = !sb_lo && !sb_hi;
  assign eb_z = !eb_lo && !eb_hi;

  always_comb begin
    loc = LOC_ABNORMAL;
    if (same && sa_hi && ea_z && sb_z && eb_lo) begin
      loc = LOC_LEFT;
    end else if (same && sa_z && ea_lo && sb_hi && eb_z) begin
      loc = LOC_RIGHT;
    end else if (!same && sa_z && ea_lo && sb_z && eb_lo) begin
      loc = LOC_LEFT;
    end else if (!same && sa_hi && ea_z && sb_hi && eb_z) begin
      loc = LOC_RIGHT;
    end else if (sa_z && ea_z && sb_z && eb_z) begin
      loc = LOC_EQUAL;
    end else if (!sa_lo && !ea_hi && sb_z && eb_z) begin
      loc = LOC_CONTAINING;
    end else if (sa_z && ea_z && !sb_lo && !eb_hi) begin
      loc = LOC_CONTAINED;
    end
  end

endmodule

`default_nettype wire

[src/olce_stretch.sv]
`default_nettype none

module olce_stretch
  import olce_pkg::*;
#(
  parameter int W = OLCE_COORD_BITS + 3
) (
  input  logic                same,
  input  logic [TOL_W-1:0]    margin,
  input  logic signed [W-1:0] a_start,
  input  logic signed [W-1:0] a_end,
  input  logic signed [W-1:0] a_len,
  input  logic signed [W-1:0] b_start,
  input  logic signed [W-1:0] b_end,
  input  logic signed [W-1:0] b_len,
  output logic signed [W-1:0] new_a_start,
  output logic signed [W-1:0] new_a_end,
  output logic signed [W-1:0] new_b_start,
  output logic signed [W-1:0] new_b_end
);

  logic signed [W-1:0] m;
  logic a0, b0, a1, b1;

  assign m  = W'(margin);
  assign a0 = a_start <= m;
  assign b0 = b_start <= m;
  assign a1 = a_end >= (a_len - m);
  assign b1 = b_end >= (b_len - m);

  always_comb begin
    new_a_start = a_start;
    new_a_end   = a_end;
    new_b_start = b_start;
    new_b_end   = b_end;
    if (same) begin
      // starts pulled to zero; when only one is near, the other start moves along
      if (a0 && b0) begin
        new_a_start = '0;
        new_b_start = '0;
      end else if (a0) begin
        new_b_start = b_start - a_start;
        new_a_start = '0;
      end else if (b0) begin
        new_a_start = a_start - b_start;
        new_b_start = '0;
      end
      // ends pushed to the read lengths; when only one is near, the other end moves along
      if (a1 && b1) begin
        new_a_end = a_len;
        new_b_end = b_len;
      end else if (a1) begin
        new_b_end = b_end + a_len - a_end;
        new_a_end = a_len;
      end else if (b1) begin
        new_a_end = a_end + b_len - b_end;
        new_b_end = b_len;
      end
    end else begin
      // a start pairs with b end
      if (a0 && b1) begin
        new_a_start = '0;
        new_b_end   = b_len;
      end else if (a0) begin
        new_b_end   = b_end + a_start;
        new_a_start = '0;
      end else if (b1) begin
        new_a_start = a_start - b_len + b_end;
        new_b_end   = b_len;
      end
      // b start pairs with a end
      if (b0 && a1) begin
        new_b_start = '0;
        new_a_end   = a_len;
      end else if (b0) begin
        new_a_end   = a_end + b_start;
        new_b_start = '0;
      end else if (a1) begin
        new_b_start = b_start - a_len + a_end;
        new_a_end   = a_len;
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/overlap_location_classify_extend_test.sv]
module overlap_location_classify_extend_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olce_pkg::*;

  localparam int CB = OLCE_COORD_BITS;
  localparam int IN_W = 8 * ((6 * CB + 2 + TOL_W + 7) / 8);
  localparam longint COORD_MAX = (longint'(1) << CB) - 1;
  localparam int N_RANDOM = 1800;

  // s_tuser carries the mode
  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_EXTEND   = 1'b1;

  // m_tdata field positions, lowest bit up
  localparam int LOC_LSB = 0;
  localparam int OK_BIT  = LOC_W;
  localparam int NAS_LSB = LOC_W + 1;
  localparam int NAE_LSB = NAS_LSB + OUT_W;
  localparam int NBS_LSB = NAE_LSB + OUT_W;
  localparam int NBE_LSB = NBS_LSB + OUT_W;

  // one overlap record as the sender sees it
  typedef struct {
    logic          mode;
    logic [CB-1:0] a_start;
    logic [CB-1:0] a_end;
    logic [CB-1:0] a_len;
    logic [CB-1:0] b_start;
    logic [CB-1:0] b_end;
    logic [CB-1:0] b_len;
    logic          same;
    logic [15:0]   tol;
    logic          from_b;
  } overlap_t;

  // coordinates widened so that stretching can go below zero
  typedef struct {
    longint a_s, a_e, a_l, b_s, b_e, b_l;
  } span_t;

  typedef struct {
    loc_t            location;
    logic            ok;
    logic [OUT_W-1:0] a_s, a_e, b_s, b_e;
  } placement_t;

  // -------------------------------------------------------------------------
  // expected placements, one per accepted overlap
  // -------------------------------------------------------------------------
  class overlap_board;
    placement_t pending_q[$];
    int errors;
    int checked;
    int n_items;
    int n_extend;
    int n_stretched;
    int label_seen[6];

    function new();
      errors = 0;
      checked = 0;
      n_items = 0;
      n_extend = 0;
      n_stretched = 0;
      foreach (label_seen[i]) label_seen[i] = 0;
    endfunction

    // -1 short of the bound, +1 past it, 0 within slack
    function int side_of(longint v, longint bound, longint slack);
      if (v < bound - slack) return -1;
      if (v > bound + slack) return 1;
      return 0;
    endfunction

    function loc_t label_of(span_t s, bit same, longint slack);
      int sa, ea, sb, eb;
      sa = side_of(s.a_s, 0, slack);
      ea = side_of(s.a_e, s.a_l, slack);
      sb = side_of(s.b_s, 0, slack);
      eb = side_of(s.b_e, s.b_l, slack);
      if (same) begin
        if (sa > 0 && ea == 0 && sb == 0 && eb < 0) return LOC_LEFT;
        if (sa == 0 && ea < 0 && sb > 0 && eb == 0) return LOC_RIGHT;
      end else begin
        if (sa == 0 && ea < 0 && sb == 0 && eb < 0) return LOC_LEFT;
        if (sa > 0 && ea == 0 && sb > 0 && eb == 0) return LOC_RIGHT;
      end
      if (sa == 0 && ea == 0 && sb == 0 && eb == 0) return LOC_EQUAL;
      if (sa >= 0 && ea <= 0 && (sa != 0 || ea != 0) && sb == 0 && eb == 0)
        return LOC_CONTAINING;
      if (sa == 0 && ea == 0 && sb >= 0 && eb <= 0 && (sb != 0 || eb != 0))
        return LOC_CONTAINED;
      return LOC_ABNORMAL;
    endfunction

    function loc_t restate_for_b(loc_t l, bit same);
      case (l)
        LOC_LEFT:       return same ? LOC_RIGHT : LOC_LEFT;
        LOC_RIGHT:      return same ? LOC_LEFT : LOC_RIGHT;
        LOC_CONTAINING: return LOC_CONTAINED;
        LOC_CONTAINED:  return LOC_CONTAINING;
        default:        return l;
      endcase
    endfunction

    // pull ends within m of a bound onto it; the partner end moves along
    function span_t stretch_span(span_t s, bit same, longint m);
      bit near_as, near_ae, near_bs, near_be;
      near_as = s.a_s <= m;
      near_bs = s.b_s <= m;
      if (same) begin
        if (near_as && near_bs) begin
          s.a_s = 0;
          s.b_s = 0;
        end else if (near_as) begin
          s.b_s -= s.a_s;
          s.a_s = 0;
        end else if (near_bs) begin
          s.a_s -= s.b_s;
          s.b_s = 0;
        end
        near_ae = s.a_e >= s.a_l - m;
        near_be = s.b_e >= s.b_l - m;
        if (near_ae && near_be) begin
          s.a_e = s.a_l;
          s.b_e = s.b_l;
        end else if (near_ae) begin
          s.b_e += s.a_l - s.a_e;
          s.a_e = s.a_l;
        end else if (near_be) begin
          s.a_e += s.b_l - s.b_e;
          s.b_e = s.b_l;
        end
      end else begin
        // opposite strand: a start pairs with b end, then b start with a end
        near_be = s.b_e >= s.b_l - m;
        if (near_as && near_be) begin
          s.a_s = 0;
          s.b_e = s.b_l;
        end else if (near_as) begin
          s.b_e += s.a_s;
          s.a_s = 0;
        end else if (near_be) begin
          s.a_s -= s.b_l - s.b_e;
          s.b_e = s.b_l;
        end
        near_ae = s.a_e >= s.a_l - m;
        if (near_bs && near_ae) begin
          s.b_s = 0;
          s.a_e = s.a_l;
        end else if (near_bs) begin
          s.a_e += s.b_s;
          s.b_s = 0;
        end else if (near_ae) begin
          s.b_s -= s.a_l - s.a_e;
          s.a_e = s.a_l;
        end
      end
      return s;
    endfunction

    function logic [OUT_W-1:0] sat_out(longint v);
      longint lo, hi;
      lo = -(longint'(1) << (OUT_W - 1));
      hi = (longint'(1) << (OUT_W - 1)) - 1;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v[OUT_W-1:0];
    endfunction

    // work out the placement for an accepted overlap and queue it
    function void note_item(logic [IN_W-1:0] d, logic mode);
      span_t s;
      bit same, from_b;
      longint tol;
      loc_t loc;
      placement_t r;
      s.a_s = longint'(d[0 +: CB]);
      s.a_e = longint'(d[CB +: CB]);
      s.a_l = longint'(d[2*CB +: CB]);
      s.b_s = longint'(d[3*CB +: CB]);
      s.b_e = longint'(d[4*CB +: CB]);
      s.b_l = longint'(d[5*CB +: CB]);
      same = d[6*CB];
      tol = longint'(d[6*CB+1 +: TOL_W]);
      from_b = d[6*CB+1+TOL_W];
      r.ok = 1'b0;
      n_items++;
      if (mode == MODE_CLASSIFY) begin
        loc = label_of(s, same, tol);
      end else begin
        n_extend++;
        if (label_of(s, same, 0) != LOC_ABNORMAL) begin
          r.ok = 1'b1;
        end else if (label_of(s, same, tol) != LOC_ABNORMAL) begin
          s = stretch_span(s, same, tol);
          r.ok = 1'b1;
          n_stretched++;
        end
        loc = label_of(s, same, 0);
      end
      if (from_b) loc = restate_for_b(loc, same);
      label_seen[loc]++;
      r.location = loc;
      r.a_s = sat_out(s.a_s);
      r.a_e = sat_out(s.a_e);
      r.b_s = sat_out(s.b_s);
      r.b_e = sat_out(s.b_e);
      pending_q.push_back(r);
    endfunction

    function void field_mismatch(string name, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] t);
      placement_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none got %h", $time, t);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (t[LOC_LSB +: LOC_W] != e.location)
        field_mismatch("location", longint'(e.location), longint'(t[LOC_LSB +: LOC_W]));
      if (t[OK_BIT] != e.ok)
        field_mismatch("extend_ok", longint'(e.ok), longint'(t[OK_BIT]));
      if (t[NAS_LSB +: OUT_W] != e.a_s)
        field_mismatch("new_a_start", longint'(e.a_s), longint'(t[NAS_LSB +: OUT_W]));
      if (t[NAE_LSB +: OUT_W] != e.a_e)
        field_mismatch("new_a_end", longint'(e.a_e), longint'(t[NAE_LSB +: OUT_W]));
      if (t[NBS_LSB +: OUT_W] != e.b_s)
        field_mismatch("new_b_start", longint'(e.b_s), longint'(t[NBS_LSB +: OUT_W]));
      if (t[NBE_LSB +: OUT_W] != e.b_e)
        field_mismatch("new_b_end", longint'(e.b_e), longint'(t[NBE_LSB +: OUT_W]));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // block under test
  // -------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   s_tuser = MODE_CLASSIFY;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  overlap_board board;
  int burst_left = 0;
  int stall_cyc = 0;
  int stall_style = 0;

  overlap_location_classify_extend i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // both handshakes are sampled with pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_item(s_tdata, s_tuser);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  // receiver backpressure: the style is redrawn at random at regular intervals
  // 0 always ready, 1 mostly ready, 2 mostly stalled, 3 periodic stall
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 256 == 255) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (stall_cyc % 5 != 0);
    endcase
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  function automatic overlap_t mk(int mode, longint as_v, longint ae_v, longint al_v,
                                  longint bs_v, longint be_v, longint bl_v,
                                  int same, longint tol, int from_b);
    overlap_t it;
    it.mode = mode[0];
    it.a_start = as_v[CB-1:0];
    it.a_end = ae_v[CB-1:0];
    it.a_len = al_v[CB-1:0];
    it.b_start = bs_v[CB-1:0];
    it.b_end = be_v[CB-1:0];
    it.b_len = bl_v[CB-1:0];
    it.same = same[0];
    it.tol = tol[15:0];
    it.from_b = from_b[0];
    return it;
  endfunction

  // place one end relative to its bound: 0 inside slack, +1 past, -1 short
  function automatic logic [CB-1:0] place_end(longint bound, longint slack, int sd);
    longint v;
    longint reach;
    reach = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 50) : $urandom_range(0, 5000);
    case (sd)
      0: v = ($urandom_range(0, 2) == 0) ? bound :
             bound + longint'($urandom_range(0, int'(2 * slack))) - slack;
      1: v = bound + slack + 1 + reach;
      default: v = bound - slack - 1 - reach;
    endcase
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[CB-1:0];
  endfunction

  // mostly shaped overlaps near the read bounds, some pure noise
  function automatic overlap_t gen_overlap();
    overlap_t it;
    longint t, al, bl;
    int sa, ea, sb, eb, shape, pick;
    it.mode = 1'($urandom_range(0, 1));
    it.same = 1'($urandom_range(0, 1));
    it.from_b = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      it.a_start = CB'($urandom);
      it.a_end = CB'($urandom);
      it.a_len = CB'($urandom);
      it.b_start = CB'($urandom);
      it.b_end = CB'($urandom);
      it.b_len = CB'($urandom);
      it.tol = 16'($urandom);
      return it;
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) t = 0;
    else if (pick < 7) t = $urandom_range(1, 64);
    else if (pick < 9) t = $urandom_range(65, 2000);
    else t = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 65535);
    it.tol = t[15:0];
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      al = $urandom_range(0, 10);
      bl = $urandom_range(0, 10);
    end else if (pick < 3) begin
      al = $urandom_range(0, int'(COORD_MAX));
      bl = $urandom_range(0, int'(COORD_MAX));
    end else begin
      al = $urandom_range(500, 20000);
      bl = $urandom_range(500, 20000);
    end
    it.a_len = al[CB-1:0];
    it.b_len = bl[CB-1:0];
    shape = $urandom_range(0, 6);
    case (shape)
      0: begin  // left
        if (it.same) {sa, ea, sb, eb} = {32'sd1, 32'sd0, 32'sd0, -32'sd1};
        else {sa, ea, sb, eb} = {32'sd0, -32'sd1, 32'sd0, -32'sd1};
      end
      1: begin  // right
        if (it.same) {sa, ea, sb, eb} = {32'sd0, -32'sd1, 32'sd1, 32'sd0};
        else {sa, ea, sb, eb} = {32'sd1, 32'sd0, 32'sd1, 32'sd0};
      end
      2: {sa, ea, sb, eb} = {32'sd0, 32'sd0, 32'sd0, 32'sd0};
      3: begin  // a holds b
        sa = $urandom_range(0, 1);
        ea = (sa != 0) ? -int'($urandom_range(0, 1)) : -1;
        sb = 0;
        eb = 0;
      end
      4: begin  // b holds a
        sb = $urandom_range(0, 1);
        eb = (sb != 0) ? -int'($urandom_range(0, 1)) : -1;
        sa = 0;
        ea = 0;
      end
      default: begin
        sa = int'($urandom_range(0, 2)) - 1;
        ea = int'($urandom_range(0, 2)) - 1;
        sb = int'($urandom_range(0, 2)) - 1;
        eb = int'($urandom_range(0, 2)) - 1;
      end
    endcase
    it.a_start = place_end(0, t, sa);
    it.a_end = place_end(al, t, ea);
    it.b_start = place_end(0, t, sb);
    it.b_end = place_end(bl, t, eb);
    return it;
  endfunction

  // bursts of random length with random gaps between them
  task automatic send_overlap(overlap_t it);
    logic [IN_W-1:0] d;
    int gap;
    d = '0;
    d[0 +: CB] = it.a_start;
    d[CB +: CB] = it.a_end;
    d[2*CB +: CB] = it.a_len;
    d[3*CB +: CB] = it.b_start;
    d[4*CB +: CB] = it.b_end;
    d[5*CB +: CB] = it.b_len;
    d[6*CB] = it.same;
    d[6*CB+1 +: TOL_W] = it.tol;
    d[6*CB+1+TOL_W] = it.from_b;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= it.mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // each proper label at zero slack, with both strands and both points of view mixed in
    send_overlap(mk(MODE_CLASSIFY, 0, 1000, 1000, 0, 500, 500, 1, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, 300, 1000, 1000, 0, 700, 2000, 1, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, 300, 1000, 1000, 0, 700, 2000, 1, 0, 1));
    send_overlap(mk(MODE_CLASSIFY, 0, 700, 1000, 300, 2000, 2000, 1, 0, 1));
    send_overlap(mk(MODE_CLASSIFY, 0, 700, 1000, 0, 600, 900, 0, 0, 1));
    send_overlap(mk(MODE_CLASSIFY, 300, 1000, 1000, 200, 900, 900, 0, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, 100, 900, 1000, 0, 800, 800, 1, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, 100, 900, 1000, 0, 800, 800, 0, 0, 1));
    send_overlap(mk(MODE_CLASSIFY, 0, 1000, 1000, 100, 500, 1000, 1, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, 0, 1000, 1000, 100, 500, 1000, 0, 0, 1));
    // starts within the slack, then an abnormal overlap
    send_overlap(mk(MODE_CLASSIFY, 50, 1000, 1000, 20, 500, 1000, 1, 100, 0));
    send_overlap(mk(MODE_CLASSIFY, 500, 600, 1000, 500, 600, 1000, 1, 0, 0));
    // field extremes
    send_overlap(mk(MODE_CLASSIFY, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, 1, 65535, 1));
    send_overlap(mk(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_overlap(mk(MODE_CLASSIFY, COORD_MAX, 0, 5, 3, COORD_MAX, 0, 0, 65535, 0));
    // extend: already proper, stretched on every pairing, failed
    send_overlap(mk(MODE_EXTEND, 0, 1000, 1000, 0, 500, 500, 1, 10, 0));
    send_overlap(mk(MODE_EXTEND, 5, 995, 1000, 8, 497, 500, 1, 10, 0));
    send_overlap(mk(MODE_EXTEND, 5, 995, 1000, 300, 497, 500, 1, 10, 0));
    send_overlap(mk(MODE_EXTEND, 300, 995, 1000, 6, 700, 2000, 1, 10, 1));
    send_overlap(mk(MODE_EXTEND, 4, 700, 1000, 7, 600, 900, 0, 10, 0));
    send_overlap(mk(MODE_EXTEND, 300, 996, 1000, 200, 893, 900, 0, 10, 0));
    send_overlap(mk(MODE_EXTEND, 500, 600, 1000, 500, 600, 1000, 1, 10, 0));
    // inconsistent coordinates, then field extremes in extend mode
    send_overlap(mk(MODE_EXTEND, 900, 100, 1000, 5, 3000, 2000, 1, 20, 0));
    send_overlap(mk(MODE_EXTEND, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                    COORD_MAX, 0, 65535, 1));

    for (int n = 0; n < N_RANDOM; n++) send_overlap(gen_overlap());
    s_tvalid <= 1'b0;

    // drain, then give a late extra result time to show up
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d overlaps (%0d extend, %0d stretched), %0d results checked",
             board.n_items, board.n_extend, board.n_stretched, board.checked);
    $display("labels left %0d right %0d equal %0d containing %0d contained %0d abnormal %0d",
             board.label_seen[LOC_LEFT], board.label_seen[LOC_RIGHT],
             board.label_seen[LOC_EQUAL], board.label_seen[LOC_CONTAINING],
             board.label_seen[LOC_CONTAINED], board.label_seen[LOC_ABNORMAL]);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", board.pending_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

[overlap_location_classify_extend.f]
+incdir+src
src/olce_pkg.sv
src/olce_classify.sv
src/olce_stretch.sv
src/overlap_location_classify_extend.sv
tb/sv/overlap_location_classify_extend_test.sv
